// ----- design/ctt_pkg.sv -----
// shared types and codes of the tcp connection tracker
// depends on nothing; used by ctt_hash and the top level
package ctt_pkg;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;

  // connection phase codes
  localparam logic [1:0] PH_NONE        = 2'd0;
  localparam logic [1:0] PH_SYN_SENT    = 2'd1;
  localparam logic [1:0] PH_ESTABLISHED = 2'd2;

  // action codes
  localparam logic ACT_TRACK = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // seed of the three-word hash with initval 0
  localparam logic [31:0] HASH_SEED = 32'hdeadbefb;

  localparam int unsigned ACTIVE_W  = 13;
  localparam int unsigned DROPPED_W = 32;

  // one way of a bucket row
  typedef struct packed {
    logic        valid;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [1:0]  phase;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] seen_tick;
  } slot_t;

endpackage

// ----- design/ctt_if.sv -----
// request and response channels of the tcp connection tracker
// depends on nothing
interface ctt_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic        syn_flag;
  logic        ack_flag;
  logic [31:0] seq_value;
  logic [31:0] ack_value;
  logic [31:0] now_tick;

  modport source (output valid, action, source_addr, dest_addr, source_port, dest_port,
                  syn_flag, ack_flag, seq_value, ack_value, now_tick, input ready);
  modport sink (input valid, action, source_addr, dest_addr, source_port, dest_port,
                syn_flag, ack_flag, seq_value, ack_value, now_tick, output ready);
endinterface

interface ctt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [1:0]  conn_phase;
  logic [12:0] active_total;
  logic [31:0] dropped_total;

  modport source (output valid, status, hit, conn_phase, active_total, dropped_total,
                  input ready);
  modport sink (input valid, status, hit, conn_phase, active_total, dropped_total,
                output ready);
endinterface

// ----- design/ctt_ram.sv -----
// generic single-write, single-read ram with registered read data
// depends on nothing
module ctt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/ctt_hash.sv -----
// bucket hash unit: three-word mix one line per cycle, then remainder by reciprocal multiply
// depends on ctt_pkg
module ctt_hash #(
  parameter int unsigned BUCKETS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                a_i,
  input  logic [31:0]                b_i,
  input  logic [31:0]                c_i,
  output logic                       done_o,
  output logic [$clog2(BUCKETS)-1:0] bucket_o
);

  localparam int unsigned IDX_W = $clog2(BUCKETS);
  localparam int unsigned SH    = $clog2(BUCKETS);
  // exact quotient of a 32-bit value: floor(c * RECIP / 2^(32+SH))
  localparam logic [32:0] RECIP = 33'(((64'd1 << (32 + SH)) / 64'(BUCKETS)) + 64'd1);

  typedef enum logic [1:0] {H_IDLE, H_MIX, H_MUL, H_SUB} hstate_e;

  hstate_e     state_q;
  logic [2:0]  step_q;
  logic [31:0] a_q, b_q, c_q;
  logic [31:0] a_d, b_d, c_d;
  logic [31:0] quo_q;
  logic [64:0] prod;
  logic [IDX_W-1:0] rem_q;
  logic             done_q;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    rotl = (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

  // one line of the mix per step
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    case (step_q)
      3'd0: c_d = (c_q ^ b_q) - rotl(b_q, 5'd14);
      3'd1: a_d = (a_q ^ c_q) - rotl(c_q, 5'd11);
      3'd2: b_d = (b_q ^ a_q) - rotl(a_q, 5'd25);
      3'd3: c_d = (c_q ^ b_q) - rotl(b_q, 5'd16);
      3'd4: a_d = (a_q ^ c_q) - rotl(c_q, 5'd4);
      3'd5: b_d = (b_q ^ a_q) - rotl(a_q, 5'd14);
      3'd6: c_d = (c_q ^ b_q) - rotl(b_q, 5'd24);
      default: c_d = c_q;
    endcase
  end

  // quotient estimate by the reciprocal
  assign prod = {33'd0, c_q} * {32'd0, RECIP};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        H_IDLE: begin
          if (start_i) begin
            a_q     <= a_i + ctt_pkg::HASH_SEED;
            b_q     <= b_i + ctt_pkg::HASH_SEED;
            c_q     <= c_i + ctt_pkg::HASH_SEED;
            step_q  <= '0;
            state_q <= H_MIX;
          end
        end
        H_MIX: begin
          a_q <= a_d;
          b_q <= b_d;
          c_q <= c_d;
          if (step_q == 3'd6) begin
            step_q  <= '0;
            state_q <= H_MUL;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        H_MUL: begin
          quo_q   <= 32'(prod >> (32 + SH));
          state_q <= H_SUB;
        end
        H_SUB: begin
          rem_q   <= IDX_W'(c_q - quo_q * 32'(BUCKETS));
          done_q  <= 1'b1;
          state_q <= H_IDLE;
        end
        default: state_q <= H_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule

// ----- design/tcp_connection_tracker_top.sv -----
// top level of the tcp connection tracker: sequencer, bucket update and result register
// depends on ctt_pkg, ctt_if, ctt_ram and ctt_hash
//
// Usage:
//   req_i carries one request per packet (action track) or a clear request.
//   rsp_o returns exactly one result per request, in order.
//   A track request passes through the hash mix, one line per step, a reciprocal
//   multiply and a subtract for the remainder by BUCKETS, a bucket ram read, and
//   the compare, update and write back of all ways of the bucket at once.
//   req_i.ready returns with the result, so no new track request is taken while
//   one is in work.
//   A clear request registers its result once rsp_o is free and then sweeps
//   the bucket ram, one row per cycle, with req_i.ready low.
//   After reset the same sweep over all BUCKETS rows runs before the first request
//   is taken; the active and dropped counts start at zero.
//   One request is in work at a time. The result register lets the next request
//   be taken while a result waits; if rsp_o is stalled, the next result holds in
//   the update cycle, and nothing is written until it can be delivered.
module tcp_connection_tracker_top #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctt_req_if.sink   req_i,
  ctt_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W  = $clog2(BUCKETS);
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CNT_W  = $clog2(BUCKETS * WAYS + 1);
  localparam int unsigned SLOT_W = $bits(ctt_pkg::slot_t);
  localparam int unsigned ROW_W  = WAYS * SLOT_W;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_HASH, S_EVAL} state_e;

  state_e state_q;
  logic [IDX_W-1:0] sweep_q;
  logic [IDX_W-1:0] bucket_q;
  logic [CNT_W-1:0] active_q;
  logic [31:0]      dropped_q;

  // request fields held during work
  logic        action_q;
  logic [31:0] src_q, dst_q;
  logic [15:0] sport_q, dport_q;
  logic        syn_q, ack_q;
  logic [31:0] seqv_q, ackv_q, now_q;

  // result register
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic        out_hit_q;
  logic [1:0]  out_phase_q;
  logic [CNT_W-1:0] out_active_q;
  logic [31:0] out_dropped_q;

  logic hash_start, hash_done;
  logic [IDX_W-1:0] hash_bucket;

  ctt_pkg::slot_t [WAYS-1:0] rd_row, wr_row;
  logic [ROW_W-1:0] ram_rdata, ram_wdata;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;

  logic             fire, out_free;
  logic             found, free_found, lone_syn;
  logic [WAY_W-1:0] hit_idx, free_idx;
  logic             upd_we;
  logic [1:0]       res_status, res_phase;
  logic             res_hit;
  logic [CNT_W-1:0] active_d;

  assign req_i.ready = (state_q == S_IDLE);
  assign fire        = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign lone_syn    = syn_q && !ack_q;

  assign hash_start = fire && (req_i.action == ctt_pkg::ACT_TRACK);

  ctt_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .a_i      (req_i.source_addr),
    .b_i      (req_i.dest_addr),
    .c_i      ({req_i.source_port, req_i.dest_port}),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  ctt_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (hash_bucket),
    .rdata_o (ram_rdata)
  );

  assign ram_re = (state_q == S_HASH) && hash_done;
  assign rd_row = ram_rdata;

  // way search: matching way and lowest free way
  always_comb begin
    found      = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = 0; i < int'(WAYS); i++) begin
      if (rd_row[i].valid) begin
        if (!found && rd_row[i].addrs == {src_q, dst_q} &&
            rd_row[i].ports == {sport_q, dport_q}) begin
          found   = 1'b1;
          hit_idx = WAY_W'(i);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_idx   = WAY_W'(i);
      end
    end
  end

  // bucket update and result
  always_comb begin
    wr_row     = rd_row;
    upd_we     = 1'b0;
    res_status = ctt_pkg::ST_OK;
    res_hit    = 1'b0;
    res_phase  = ctt_pkg::PH_NONE;
    active_d   = active_q;
    if (found) begin
      upd_we                    = 1'b1;
      res_hit                   = 1'b1;
      wr_row[hit_idx].seen_tick = now_q;
      if (lone_syn) begin
        wr_row[hit_idx].phase = ctt_pkg::PH_SYN_SENT;
      end else if (syn_q && ack_q) begin
        wr_row[hit_idx].phase = ctt_pkg::PH_ESTABLISHED;
        wr_row[hit_idx].seq   = seqv_q;
        wr_row[hit_idx].ack   = ackv_q;
      end
      res_phase = wr_row[hit_idx].phase;
    end else if (!lone_syn) begin
      res_status = ctt_pkg::ST_INVALID;
    end else if (!free_found) begin
      res_status = ctt_pkg::ST_NO_ROOM;
    end else begin
      upd_we                     = 1'b1;
      wr_row[free_idx].valid     = 1'b1;
      wr_row[free_idx].addrs     = {src_q, dst_q};
      wr_row[free_idx].ports     = {sport_q, dport_q};
      wr_row[free_idx].phase     = ctt_pkg::PH_SYN_SENT;
      wr_row[free_idx].seq       = seqv_q;
      wr_row[free_idx].ack       = '0;
      wr_row[free_idx].seen_tick = now_q;
      res_phase                  = ctt_pkg::PH_SYN_SENT;
      active_d                   = active_q + CNT_W'(1);
    end
  end

  // ram write: sweep rows in clear, update row in eval
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bucket_q;
    ram_wdata = wr_row;
    if (state_q == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_q;
      ram_wdata = '0;
    end else if (state_q == S_EVAL && out_free && action_q == ctt_pkg::ACT_TRACK) begin
      ram_we = upd_we;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (fire) begin
      action_q <= req_i.action;
      src_q    <= req_i.source_addr;
      dst_q    <= req_i.dest_addr;
      sport_q  <= req_i.source_port;
      dport_q  <= req_i.dest_port;
      syn_q    <= req_i.syn_flag;
      ack_q    <= req_i.ack_flag;
      seqv_q   <= req_i.seq_value;
      ackv_q   <= req_i.ack_value;
      now_q    <= req_i.now_tick;
    end
    if (state_q == S_HASH && hash_done) begin
      bucket_q <= hash_bucket;
    end
  end

  // sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      sweep_q     <= '0;
      active_q    <= '0;
      dropped_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // result valid: set on update, cleared when taken
      if (state_q == S_EVAL && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          if (sweep_q == IDX_W'(BUCKETS - 1)) begin
            state_q <= S_IDLE;
          end
          sweep_q <= sweep_q + IDX_W'(1);
        end
        S_IDLE: begin
          if (fire) begin
            state_q <= (req_i.action == ctt_pkg::ACT_CLEAR) ? S_EVAL : S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (out_free) begin
            if (action_q == ctt_pkg::ACT_CLEAR) begin
              dropped_q     <= dropped_q + 32'(active_q);
              active_q      <= '0;
              out_status_q  <= ctt_pkg::ST_OK;
              out_hit_q     <= 1'b0;
              out_phase_q   <= ctt_pkg::PH_NONE;
              out_active_q  <= '0;
              out_dropped_q <= dropped_q + 32'(active_q);
              sweep_q       <= '0;
              state_q       <= S_CLR;
            end else begin
              active_q      <= active_d;
              out_status_q  <= res_status;
              out_hit_q     <= res_hit;
              out_phase_q   <= res_phase;
              out_active_q  <= active_d;
              out_dropped_q <= dropped_q;
              state_q       <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.conn_phase    = out_phase_q;
  assign rsp_o.active_total  = ctt_pkg::ACTIVE_W'(out_active_q);
  assign rsp_o.dropped_total = out_dropped_q;

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> !req_i.ready)
    else $error("request taken while another is in work");

  // a hit is always a good result
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.hit |-> rsp_o.status == ctt_pkg::ST_OK)
    else $error("hit with error status");

  // a failed lookup reports no phase
  a_err_no_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ctt_pkg::ST_OK |-> rsp_o.conn_phase == ctt_pkg::PH_NONE)
    else $error("error result with phase");

  // the count of tracked entries stays within the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= CNT_W'(BUCKETS * WAYS))
    else $error("active count beyond table size");

endmodule
